[rtl/rgb565_coverage_blend_unit_assert.svh]
// Assertion macros shared by the blend unit modules.
// RCB_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// RCB_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef RGB565_COVERAGE_BLEND_UNIT_ASSERT_SVH
`define RGB565_COVERAGE_BLEND_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("blend unit assertion failed");
`define RCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("blend unit assertion failed");
`else
`define RCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/rcb_pkg.sv]
`timescale 1ns / 1ps
package rcb_pkg;

	localparam int unsigned ADDR_W = 5;

	localparam logic [2:0] REG_RESULT_MASK_A = 3'd0;
	localparam logic [2:0] REG_SPREAD_MASK_A = 3'd1;
	localparam logic [2:0] REG_RESULT_MASK_B = 3'd2;
	localparam logic [2:0] REG_SPREAD_MASK_B = 3'd3;
	localparam logic [2:0] REG_INK_COLOR     = 3'd4;
	localparam logic [2:0] REG_SHADE_COLOR   = 3'd5;
	localparam logic [2:0] REG_SHADE_ENABLE  = 3'd6;

	typedef struct packed {
		logic [7:0]  coverage;
		logic [15:0] dest_pixel;
	} rcb_in_t;

	typedef struct packed {
		logic [15:0] blended_pixel;
		logic        write_enable;
	} rcb_out_t;

	// Working colour carried between the two blends, full 32-bit intermediate
	typedef struct packed {
		logic [31:0] color;
		logic [7:0]  coverage;
	} rcb_item_t;

	typedef struct packed {
		logic [31:0] result_mask_a;
		logic [31:0] spread_mask_a;
		logic [31:0] result_mask_b;
		logic [31:0] spread_mask_b;
	} rcb_masks_t;

	typedef struct packed {
		rcb_masks_t  masks;
		logic [15:0] ink_color;
		logic [15:0] shade_color;
		logic        shade_enable;
	} rcb_cfg_t;

	// Widen a 4-bit alpha to a 0..16 weight
	function automatic logic [4:0] widen_alpha(input logic [3:0] a);
		widen_alpha = {1'b0, a} + {4'b0, a[3]};
	endfunction

endpackage

[rtl/rgb565_coverage_blend_unit.sv]
`timescale 1ns / 1ps
// RGB565 coverage blend: glyph coverage byte plus destination pixel in, blended pixel out.
// Input channel src (src_valid/src_ready/src_data): one beat per pixel, carrying the
// coverage byte (high nibble ink alpha, low nibble shadow alpha) and the current pixel.
// Output channel dst (dst_valid/dst_ready/dst_data): one beat per input beat, in order,
// with the blended pixel and a write enable that is low for zero coverage.
// Configuration through the APB port: masks, ink and shade colours, shade enable, at
// byte addresses 0x00..0x18; write them only while no beat is in flight.
// A beat accepted on src passes both stages of each blend, then the output register, to dst.
// Throughput: one beat per cycle while src_ready stays high, set by the four-stage blend pipeline (two stages
// per blend: the two weight multiplies, then the masked sum and shift) followed by a
// two-entry output buffer.
// Reset empties the pipeline and the output buffer and clears the configuration registers to zero.
// When dst stalls, the buffer parks one extra beat; only then does src_ready drop and
// the whole pipeline hold, so no beat is lost or repeated.
module rgb565_coverage_blend_unit
	import rcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              src_valid,
	output logic              src_ready,
	input  rcb_in_t           src_data,
	output logic              dst_valid,
	input  logic              dst_ready,
	output rcb_out_t          dst_data
);

	rcb_cfg_t  cfg;
	logic      en;
	rcb_item_t item_in, item_mid, item_end;
	logic      vld_mid, vld_end;
	logic      shade_apply, ink_apply;
	rcb_out_t  res;

	rcb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the pipeline whenever the output buffer has room
	assign src_ready = en;

	assign item_in.color    = {16'b0, src_data.dest_pixel};
	assign item_in.coverage = src_data.coverage;

	// Shadow blend: only with shade enabled and a nonzero low nibble
	assign shade_apply = cfg.shade_enable && (src_data.coverage[3:0] != 4'd0);

	rcb_blend u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.masks    (cfg.masks),
		.vld_in   (src_valid),
		.item_in  (item_in),
		.key      (cfg.shade_color),
		.weight   (widen_alpha(src_data.coverage[3:0])),
		.apply    (shade_apply),
		.vld_out  (vld_mid),
		.item_out (item_mid)
	);

	// Ink blend on top of the shadow result, driven by the high nibble
	assign ink_apply = item_mid.coverage[7:4] != 4'd0;

	rcb_blend u_ink (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.masks    (cfg.masks),
		.vld_in   (vld_mid),
		.item_in  (item_mid),
		.key      (cfg.ink_color),
		.weight   (widen_alpha(item_mid.coverage[7:4])),
		.apply    (ink_apply),
		.vld_out  (vld_end),
		.item_out (item_end)
	);

	// Cut the intermediate colour to 16 bits; drop the write for zero coverage
	assign res.blended_pixel = item_end.color[15:0];
	assign res.write_enable  = item_end.coverage != 8'd0;

	rcb_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (vld_end),
		.data_in   (res),
		.ready     (en),
		.vld_out   (dst_valid),
		.ready_out (dst_ready),
		.data_out  (dst_data)
	);

endmodule

[rtl/rcb_regs.sv]
`timescale 1ns / 1ps
module rcb_regs
	import rcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output rcb_cfg_t          cfg
);

	rcb_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_RESULT_MASK_A: cfg_q.masks.result_mask_a <= pwdata;
				REG_SPREAD_MASK_A: cfg_q.masks.spread_mask_a <= pwdata;
				REG_RESULT_MASK_B: cfg_q.masks.result_mask_b <= pwdata;
				REG_SPREAD_MASK_B: cfg_q.masks.spread_mask_b <= pwdata;
				REG_INK_COLOR:     cfg_q.ink_color <= pwdata[15:0];
				REG_SHADE_COLOR:   cfg_q.shade_color <= pwdata[15:0];
				REG_SHADE_ENABLE:  cfg_q.shade_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RESULT_MASK_A: prdata = cfg_q.masks.result_mask_a;
			REG_SPREAD_MASK_A: prdata = cfg_q.masks.spread_mask_a;
			REG_RESULT_MASK_B: prdata = cfg_q.masks.result_mask_b;
			REG_SPREAD_MASK_B: prdata = cfg_q.masks.spread_mask_b;
			REG_INK_COLOR:     prdata = {16'b0, cfg_q.ink_color};
			REG_SHADE_COLOR:   prdata = {16'b0, cfg_q.shade_color};
			REG_SHADE_ENABLE:  prdata = {31'b0, cfg_q.shade_enable};
			default:           prdata = '0;
		endcase
	end

endmodule

[rtl/rcb_blend.sv]
`timescale 1ns / 1ps
`include "rgb565_coverage_blend_unit_assert.svh"
module rcb_blend
	import rcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  rcb_masks_t  masks,
	input  logic        vld_in,
	input  rcb_item_t   item_in,
	input  logic [15:0] key,
	input  logic [4:0]  weight,
	input  logic        apply,
	output logic        vld_out,
	output rcb_item_t   item_out
);

	logic [31:0] ca, cb, ka, kb, pa, pb;
	logic        vld_s1, vld_s2;
	logic        apply_s1;
	rcb_item_t   item_s1, item_s2;
	logic [31:0] pa_s1, pb_s1, ca16_s1, cb16_s1;
	logic [31:0] ta, tb, sum;

	// Split channels into two groups and scale the colour difference
	assign ca = masks.spread_mask_a & item_in.color;
	assign cb = masks.spread_mask_b & item_in.color;
	assign ka = masks.spread_mask_a & {16'b0, key};
	assign kb = masks.spread_mask_b & {16'b0, key};
	assign pa = {27'b0, weight} * (ka - ca);
	assign pb = {27'b0, weight} * (kb - cb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= item_in;
			apply_s1 <= apply;
			pa_s1    <= pa;
			pb_s1    <= pb;
			ca16_s1  <= {ca[27:0], 4'b0};
			cb16_s1  <= {cb[27:0], 4'b0};
		end
	end

	// Recombine the groups and drop the weight scale
	assign ta  = masks.result_mask_a & (ca16_s1 + pa_s1);
	assign tb  = masks.result_mask_b & (cb16_s1 + pb_s1);
	assign sum = ta + tb;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.coverage <= item_s1.coverage;
			item_s2.color    <= apply_s1 ? {4'b0, sum[31:4]} : item_s1.color;
		end
	end

	assign vld_out  = vld_s2;
	assign item_out = item_s2;

	`RCB_ASSERT_NEXT(a_bypass_keeps_color, clk, arst_n, en && vld_s1 && !apply_s1, item_s2.color == $past(item_s1.color))

endmodule

[rtl/rcb_skid.sv]
`timescale 1ns / 1ps
`include "rgb565_coverage_blend_unit_assert.svh"
module rcb_skid
	import rcb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     vld_in,
	input  rcb_out_t data_in,
	output logic     ready,
	output logic     vld_out,
	input  logic     ready_out,
	output rcb_out_t data_out
);

	logic     out_vld_q, spare_vld_q;
	rcb_out_t out_q, spare_q;
	logic     push, take;

	assign ready    = !spare_vld_q;
	assign push     = vld_in && !spare_vld_q;
	assign take     = !out_vld_q || ready_out;
	assign vld_out  = out_vld_q;
	assign data_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			spare_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q   <= spare_vld_q || push;
			spare_vld_q <= 1'b0;
		end else if (push) begin
			spare_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= spare_vld_q ? spare_q : data_in;
		end else if (push) begin
			spare_q <= data_in;
		end
	end

	`RCB_ASSERT_NOW(a_spare_needs_out, clk, arst_n, spare_vld_q, out_vld_q)
	`RCB_ASSERT_NEXT(a_stalled_beat_parks, clk, arst_n, push && out_vld_q && !ready_out, spare_vld_q)
	`RCB_ASSERT_NEXT(a_spare_drains, clk, arst_n, spare_vld_q && ready_out, !spare_vld_q && out_vld_q)

endmodule
